// ----- rtl/gjwg_pkg.sv -----
`timescale 1ns / 1ps

package gjwg_pkg;

    localparam int NUM_JOINTS = 7;
    localparam int SEG_BASE   = 3000;
    localparam int SEG_WIDTH  = 5958;
    localparam int NUM_SEGS   = 11;

    localparam logic [7:0]  GAIN_RESET = 8'd40;
    localparam logic [11:0] COUNT_MID  = 12'd2048;

    // Segment code for phases below the first segment start.
    localparam logic [3:0] SEG_IDLE = 4'd15;

    // Phase at which each segment begins (segment 0 is the first ramp segment).
    localparam logic [15:0] SEG_START [NUM_SEGS] = '{
        16'(SEG_BASE + 0 * SEG_WIDTH), 16'(SEG_BASE + 1 * SEG_WIDTH),
        16'(SEG_BASE + 2 * SEG_WIDTH), 16'(SEG_BASE + 3 * SEG_WIDTH),
        16'(SEG_BASE + 4 * SEG_WIDTH), 16'(SEG_BASE + 5 * SEG_WIDTH),
        16'(SEG_BASE + 6 * SEG_WIDTH), 16'(SEG_BASE + 7 * SEG_WIDTH),
        16'(SEG_BASE + 8 * SEG_WIDTH), 16'(SEG_BASE + 9 * SEG_WIDTH),
        16'(SEG_BASE + 10 * SEG_WIDTH)
    };

    // Q16 intercepts and slopes, already divided by the servo step size.
    localparam logic signed [26:0] RAMP_A [4] = '{
        27'sd0, 27'sd44683636, -27'sd67025455, 27'sd22341818
    };
    localparam logic signed [15:0] RAMP_B [4] = '{
        16'sd7500, -16'sd18750, 16'sd15000, -16'sd3750
    };
    localparam logic signed [26:0] END_A [3] = '{
        27'sd44683636, -27'sd67025455, 27'sd22341818
    };
    localparam logic signed [15:0] END_B [3] = '{
        -16'sd8751, 16'sd11250, -16'sd3750
    };
    localparam logic signed [26:0] TAIL_A = -27'sd7447273;
    localparam logic signed [15:0] TAIL_B = 16'sd1250;

    typedef struct packed {
        logic [3:0]  seg;
        logic [12:0] seg_pos;
        logic [15:0] phase;
    } t_seg;

    typedef struct packed {
        logic signed [26:0] a;
        logic signed [15:0] b;
    } t_coef;

    // Picks the ramp for one joint in one segment; zero coefficients give
    // the resting count.
    function automatic t_coef ramp_coef(input logic [3:0] seg, input logic [2:0] joint);
        t_coef c;
        int    s;
        c.a = '0;
        c.b = '0;
        s   = int'(joint) + int'(seg) - 6;
        if (seg <= 4'd6) begin
            if (s >= 0 && s <= 3) begin
                c.a = RAMP_A[s[1:0]];
                c.b = RAMP_B[s[1:0]];
            end
        end else if (seg == 4'd7) begin
            if (joint < 3'd3) begin
                c.a = END_A[joint[1:0]];
                c.b = END_B[joint[1:0]];
            end
        end else if (seg == 4'd8) begin
            if (joint == 3'd0) begin
                c.a = TAIL_A;
                c.b = TAIL_B;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/gjwg_phase_acc.sv -----
`timescale 1ns / 1ps

module gjwg_phase_acc
    import gjwg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_acc_en,
    input  logic [15:0] i_drive_speed,
    output logic [15:0] o_phase
);

    logic [7:0]  r_gain;
    logic [15:0] r_phase;
    logic [15:0] n_phase;
    logic [23:0] w_prod;

    // Only the low 16 bits of speed times gain reach the phase, and those
    // bits are the same for signed and unsigned operands.
    assign w_prod  = 24'(i_drive_speed) * 24'(r_gain);
    assign n_phase = r_phase + w_prod[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_phase <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gain <= i_cfg_wr_data;
            end
            if (i_acc_en) begin
                r_phase <= n_phase;
            end
        end
    end

    assign o_phase = r_phase;

endmodule

// ----- rtl/gjwg_seg_dec.sv -----
`timescale 1ns / 1ps

module gjwg_seg_dec
    import gjwg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [15:0] i_phase,
    output t_seg        o_seg
);

    t_seg r_seg;
    t_seg n_seg;

    // Parallel compares against every segment start; the highest match wins.
    always_comb begin
        logic [15:0] w_diff;
        w_diff        = '0;
        n_seg.seg     = SEG_IDLE;
        n_seg.seg_pos = '0;
        n_seg.phase   = i_phase;
        for (int k = 0; k < NUM_SEGS; k++) begin
            if (i_phase >= SEG_START[k]) begin
                n_seg.seg = 4'(k);
            end
        end
        if (n_seg.seg != SEG_IDLE) begin
            w_diff        = i_phase - SEG_START[n_seg.seg];
            n_seg.seg_pos = w_diff[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

// ----- rtl/gjwg_ramp.sv -----
`timescale 1ns / 1ps

module gjwg_ramp
    import gjwg_pkg::*;
(
    input  logic [3:0]  i_seg,
    input  logic [2:0]  i_joint,
    input  logic [12:0] i_dist,
    output logic [11:0] o_count
);

    t_coef              w_coef;
    logic signed [29:0] w_prod;
    logic signed [29:0] w_sum;
    logic        [29:0] w_mag;
    logic        [11:0] w_off;

    assign w_coef = ramp_coef(i_seg, i_joint);
    assign w_prod = 30'(w_coef.b) * 30'($signed({1'b0, i_dist}));
    assign w_sum  = w_prod + 30'(w_coef.a);

    // Truncate the Q16 value toward zero.
    assign w_mag   = w_sum[29] ? 30'(-w_sum) : 30'(w_sum);
    assign w_off   = w_sum[29] ? 12'(-w_mag[27:16]) : w_mag[27:16];
    assign o_count = COUNT_MID + w_off;

endmodule

// ----- rtl/gait_joint_waveform_generator_core.sv -----
`timescale 1ns / 1ps

// Gait joint waveform generator.
// Input channel: i_valid / o_stall carry one signed drive speed per transfer.
// The speed times the phase gain is added to a 16-bit gait phase that wraps.
// Output channel: o_valid / i_stall carry two transfers per input item: leg 0
// (o_leg = 0, o_last = 0) with seven servo counts, then leg 1 (o_leg = 1,
// o_last = 1) whose counts mirror leg 0 as 4096 minus each count. Both
// carry the updated phase on o_phase_now.
// An accepted item passes the phase, segment decode and count registers
// before its leg 0 transfer; leg 1 is offered in the cycle after that
// transfer, and the single output register takes a new item only after
// the leg 1 transfer. Three pipeline registers (phase, segment decode,
// counts) let new items enter while the results of older ones still wait.
// The phase gain is written through i_cfg_wr_en / i_cfg_wr_data while idle;
// the user is bound to this, as the block itself does not enforce it.
// Reset (synchronous, active low) clears the phase to zero, sets the gain to
// 40 and empties the pipeline. When the receiver stalls, the output holds
// and the stall backs up stage by stage to o_stall.

module gait_joint_waveform_generator_core
    import gjwg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_drive_speed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_leg,
    output logic [11:0] o_joint_a,
    output logic [11:0] o_joint_b,
    output logic [11:0] o_joint_c,
    output logic [11:0] o_joint_d,
    output logic [11:0] o_joint_e,
    output logic [11:0] o_joint_f,
    output logic [11:0] o_joint_g,
    output logic [15:0] o_phase_now,
    output logic        o_last
);

    // Stage valid bits and the output leg select.
    logic r_s1_vld;
    logic r_s2_vld;
    logic r_o_vld;
    logic r_o_leg;

    logic w_out_xfer;
    logic w_out_free;
    logic w_s2_free;
    logic w_s1_free;
    logic w_s2_go;
    logic w_s1_go;
    logic w_in_xfer;

    logic [15:0] w_phase;
    t_seg        w_seg;
    logic [11:0] w_count [NUM_JOINTS];
    logic [11:0] r_count [NUM_JOINTS];
    logic [15:0] r_o_phase;

    // The output register frees up once the leg 1 transfer completes. Each
    // earlier stage may move on when the stage after it is empty or moving.
    assign w_out_xfer = r_o_vld && !i_stall;
    assign w_out_free = !r_o_vld || (w_out_xfer && r_o_leg);
    assign w_s2_go    = r_s2_vld && w_out_free;
    assign w_s2_free  = !r_s2_vld || w_out_free;
    assign w_s1_go    = r_s1_vld && w_s2_free;
    assign w_s1_free  = !r_s1_vld || w_s2_free;
    assign o_stall    = !w_s1_free;
    assign w_in_xfer  = i_valid && !o_stall;

    // Stage 1: the phase register doubles as the gait state and the stage
    // payload; it is only overwritten as its old value moves on.
    gjwg_phase_acc u_phase_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_acc_en      (w_in_xfer),
        .i_drive_speed (i_drive_speed),
        .o_phase       (w_phase)
    );

    // Stage 2: segment number and distance into the segment.
    gjwg_seg_dec u_seg_dec (
        .i_clk   (i_clk),
        .i_load  (w_s1_go),
        .i_phase (w_phase),
        .o_seg   (w_seg)
    );

    // Stage 3: one ramp evaluator per joint, all in parallel.
    for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_joint
        gjwg_ramp u_ramp (
            .i_seg   (w_seg.seg),
            .i_joint (3'(j)),
            .i_dist  (w_seg.seg_pos),
            .o_count (w_count[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            r_o_leg  <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_vld <= 1'b0;
            end

            if (w_s1_go) begin
                r_s2_vld <= 1'b1;
            end else if (w_s2_go) begin
                r_s2_vld <= 1'b0;
            end

            if (w_s2_go) begin
                r_o_vld <= 1'b1;
                r_o_leg <= 1'b0;
            end else if (w_out_xfer && !r_o_leg) begin
                r_o_leg <= 1'b1;
            end else if (w_out_xfer) begin
                r_o_vld <= 1'b0;
                r_o_leg <= 1'b0;
            end
        end
    end

    // Leg 0 counts and phase; leg 1 is derived on the way out.
    always_ff @(posedge i_clk) begin
        if (w_s2_go) begin
            r_count   <= w_count;
            r_o_phase <= w_seg.phase;
        end
    end

    assign o_valid     = r_o_vld;
    assign o_leg       = r_o_leg;
    assign o_last      = r_o_leg;
    assign o_phase_now = r_o_phase;
    assign o_joint_a   = r_o_leg ? 12'(-r_count[0]) : r_count[0];
    assign o_joint_b   = r_o_leg ? 12'(-r_count[1]) : r_count[1];
    assign o_joint_c   = r_o_leg ? 12'(-r_count[2]) : r_count[2];
    assign o_joint_d   = r_o_leg ? 12'(-r_count[3]) : r_count[3];
    assign o_joint_e   = r_o_leg ? 12'(-r_count[4]) : r_count[4];
    assign o_joint_f   = r_o_leg ? 12'(-r_count[5]) : r_count[5];
    assign o_joint_g   = r_o_leg ? 12'(-r_count[6]) : r_count[6];

    // A leg 0 transfer is always followed by a pending leg 1 result.
    a_leg1_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_leg) |=> (o_valid && o_leg))
        else $error("leg 1 result missing after leg 0 transfer");

    // Both results of one item carry the same phase.
    a_phase_shared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_leg) |=> $stable(o_phase_now))
        else $error("phase changed between leg 0 and leg 1");

    // Leg 1 counts mirror leg 0 counts (checked for joints a and g).
    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_leg) |=>
            (12'(o_joint_a + $past(o_joint_a)) == 12'd0 &&
             12'(o_joint_g + $past(o_joint_g)) == 12'd0))
        else $error("leg 1 counts do not mirror leg 0");

    // The input only stalls when the first stage is holding an item.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_vld)
        else $error("input stalled with an empty first stage");

endmodule
